FILE: src/prbp_pkg.sv
package prbp_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_PATCH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DEPTH_10 = 2'd0,
    DEPTH_12 = 2'd1,
    DEPTH_14 = 2'd2
  } depth_t;

  typedef enum logic [1:0] {
    RM_OFF    = 2'd0,
    RM_INTERP = 2'd1,
    RM_ZERO   = 2'd2
  } rmode_t;

  typedef enum logic [2:0] {
    REG_DEPTH  = 3'd0,
    REG_RBYTES = 3'd1,
    REG_RPIX   = 3'd2,
    REG_ROWS   = 3'd3,
    REG_RMODE  = 3'd4,
    REG_FORCE  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CHECK,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_RD_TAKE,
    ST_NEXT,
    ST_DIV,
    ST_WR_ISSUE,
    ST_WR_WAIT,
    ST_WR_BYTE,
    ST_DONE
  } state_t;

  localparam int PIX_W   = 14;
  localparam int COORD_W = 13;

  function automatic logic [3:0] depth_of(input logic [1:0] code);
    case (code)
      DEPTH_10: depth_of = 4'd10;
      DEPTH_12: depth_of = 4'd12;
      default:  depth_of = 4'd14;
    endcase
  endfunction

endpackage

FILE: src/prbp_ram.sv
module prbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: src/packed_raw_bad_pixel_patcher_core.sv
// Packed raw frame store with pixel read, write and defect patch.
// Input channel (in_*) takes one transaction: func, pos_x, pos_y, write_value.
// Output channel (out_*) returns exactly one transaction per input:
// pixel_value, patched, out_of_range. Config (cfg_*) is a plain write port,
// which the user must write only while the block is idle; the block itself
// does not enforce this. One item at a time. The frame lives in a
// single-port byte RAM with a registered read, so every pixel is fetched
// and stored a byte per access, two or three bytes a pixel.
// A patch sweeps a range check over the neighbours, reads the centre and,
// when interpolating, the four neighbours, takes their mean, then, if the
// value changed, read-modify-writes the pixel's bytes. Out-of-range
// and unknown operations finish early. After a result is taken the block
// returns to idle, and only there takes the next transaction.
// in_ready is high only in idle; a result sits in the output register
// until taken, and a stalled receiver simply holds the block in done.
// Reset clears control and configuration; the store is not cleared
// (its contents are undefined until written).
module packed_raw_bad_pixel_patcher_core #(
  parameter int STORE_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [12:0] in_pos_x,
  input  logic [12:0] in_pos_y,
  input  logic [13:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_pixel_value,
  output logic        out_patched,
  output logic        out_out_of_range,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import prbp_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int EW = 32; // extended address width, ample for 8191*65535+...

  // configuration
  logic [1:0]  depth_r;
  logic [15:0] rbytes_r;
  logic [12:0] rpix_r, rows_r;
  logic [1:0]  rmode_r;
  logic        force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_12; rbytes_r <= '0; rpix_r <= '0; rows_r <= '0;
      rmode_r <= RM_OFF; force_r <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEPTH:  depth_r  <= cfg_data[1:0];
        REG_RBYTES: rbytes_r <= cfg_data;
        REG_RPIX:   rpix_r   <= cfg_data[12:0];
        REG_ROWS:   rows_r   <= cfg_data[12:0];
        REG_RMODE:  rmode_r  <= cfg_data[1:0];
        REG_FORCE:  force_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath registers
  state_t      state_r, state_nxt;
  logic [1:0]  func_r;
  logic [12:0] x_r, y_r;
  logic [13:0] wv_r;
  logic [2:0]  pix_r;        // 0 centre, 1..4 neighbours
  logic [EW-1:0] base_r;     // row base
  logic [16:0] start_r;      // stream bit start
  logic [EW-1:0] a0_r;       // first word address
  logic [1:0]  bidx_r;       // byte within pixel access
  logic [23:0] acc_r;        // gathered bits, three bytes
  logic [13:0] old_r;
  logic [15:0] sum_r;
  logic [2:0]  cnt_r;
  logic [13:0] nv_r;
  logic        fits_r, swept_r, inside_r;
  logic [13:0] res_val_r;
  logic        res_chg_r, res_oor_r;
  logic [7:0]  rdata;

  logic [3:0] d;
  assign d = depth_of(depth_r);

  // pixel spans stream bits start..start+d-1 in at most two 16-bit words;
  // bytes touched in order: word0 hi(odd) , word0 lo, word1 hi ...
  // With MSB-first and hi byte at odd address, stream byte j of the row
  // lies at address base + (j ^ 1).
  logic [12:0] cur_x, cur_y;
  always_comb begin
    case (pix_r)
      3'd1: begin cur_x = x_r - 13'd2; cur_y = y_r - 13'd2; end
      3'd2: begin cur_x = x_r + 13'd2; cur_y = y_r - 13'd2; end
      3'd3: begin cur_x = x_r - 13'd2; cur_y = y_r + 13'd2; end
      3'd4: begin cur_x = x_r + 13'd2; cur_y = y_r + 13'd2; end
      default: begin cur_x = x_r; cur_y = y_r; end
    endcase
  end

  logic [16:0] last_bit;
  logic [13:0] sbyte0, sbyte2;   // stream byte index of first/last byte
  logic [EW-1:0] addr_lo, addr_hi_e, byte_addr_e;
  assign last_bit = start_r + 17'(d) - 17'd1;
  assign sbyte0 = start_r[16:3];
  assign sbyte2 = last_bit[16:3];
  // largest address touched: last stream byte with bit 0 set
  assign addr_hi_e = base_r + EW'({sbyte2[13:1], 1'b1});
  assign addr_lo   = base_r + EW'(sbyte0);
  logic [13:0] sb_cur;
  assign sb_cur = sbyte0 + 14'(bidx_r);
  assign byte_addr_e = base_r + EW'({sb_cur[13:1], ~sb_cur[0]});

  logic last_byte;
  assign last_byte = (sb_cur == sbyte2);

  // value extraction from gathered bytes: acc holds bytes MSB-first
  logic [23:0] aligned;
  logic [13:0] pix_val;
  logic [1:0]  nbytes;
  assign nbytes = 2'(sbyte2 - sbyte0);
  always_comb begin
    aligned = acc_r << (5'd8 * 5'(2'd2 - nbytes));
    aligned = aligned << start_r[2:0];
    pix_val = 14'(aligned[23:10] >> (4'd14 - d));
  end

  // write merge: build new byte for current position
  logic [23:0] wmask_al, wval_al;
  logic [7:0]  wbyte_mask, wbyte_val, new_byte;
  logic [13:0] dmask;
  assign dmask = 14'((15'd1 << d) - 15'd1);
  always_comb begin
    wmask_al = ({dmask, 10'd0} << (4'd14 - d)) >> start_r[2:0];
    wval_al  = ({nv_r & dmask, 10'd0} << (4'd14 - d)) >> start_r[2:0];
    case (bidx_r)
      2'd0: begin wbyte_mask = wmask_al[23:16]; wbyte_val = wval_al[23:16]; end
      2'd1: begin wbyte_mask = wmask_al[15:8];  wbyte_val = wval_al[15:8];  end
      default: begin wbyte_mask = wmask_al[7:0]; wbyte_val = wval_al[7:0]; end
    endcase
    new_byte = (rdata & ~wbyte_mask) | (wbyte_val & wbyte_mask);
  end

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  assign ram_addr = byte_addr_e[AW-1:0];
  assign ram_we = (state_r == ST_WR_BYTE);

  prbp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(new_byte), .rdata(rdata)
  );

  logic inside_c, interp_c;
  assign inside_c = (x_r >= 13'd2) && (14'(x_r) + 14'd2 < 14'(rpix_r)) &&
                    (y_r >= 13'd2) && (14'(y_r) + 14'd2 < 14'(rows_r));
  assign interp_c = force_r || (rmode_r == RM_INTERP);
  logic fits_c;
  assign fits_c = (addr_hi_e < EW'(STORE_BYTES)) && (addr_lo < EW'(STORE_BYTES));
  logic need_nb;
  assign need_nb = (func_r == FUNC_PATCH) && inside_r && interp_c;

  // truncated mean of the nonzero neighbours; a third by reciprocal multiply
  logic [32:0] third;
  logic [15:0] mean_c;
  logic [13:0] nv_c;
  assign third = 33'(sum_r) * 33'd43691;
  always_comb begin
    case (cnt_r)
      3'd2:    mean_c = sum_r >> 1;
      3'd3:    mean_c = third[32:17];
      3'd4:    mean_c = sum_r >> 2;
      default: mean_c = sum_r;
    endcase
    nv_c = (need_nb && cnt_r != 3'd0) ? mean_c[13:0] : nv_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = (in_func == FUNC_NONE) ? ST_DONE : ST_ADDR;
      ST_ADDR:     state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!fits_c) state_nxt = ST_DONE;
        else if (func_r == FUNC_WRITE) state_nxt = ST_WR_ISSUE;
        else if (fits_r) state_nxt = ST_NEXT;   // neighbour in range, step on
        else if (func_r == FUNC_PATCH && pix_r == 3'd0 && !swept_r && inside_c)
          state_nxt = ST_NEXT; // check all neighbours first
        else state_nxt = ST_RD_ISSUE;
      end
      ST_RD_ISSUE: state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:  state_nxt = ST_RD_TAKE;
      ST_RD_TAKE:  state_nxt = last_byte ? ST_NEXT : ST_RD_ISSUE;
      ST_NEXT: begin
        if (func_r == FUNC_READ) state_nxt = ST_DONE;
        else if (fits_r) state_nxt = ST_ADDR;       // range check sweep
        else if (pix_r == 3'd4) state_nxt = ST_DIV;
        else if (pix_r == 3'd0 && !need_nb) state_nxt = ST_DIV;
        else state_nxt = ST_ADDR;
      end
      ST_DIV:      state_nxt = (nv_c != old_r) ? ST_WR_ISSUE : ST_DONE;
      ST_WR_ISSUE: state_nxt = ST_WR_WAIT;
      ST_WR_WAIT:  state_nxt = ST_WR_BYTE;
      ST_WR_BYTE:  state_nxt = last_byte ? ST_DONE : ST_WR_ISSUE;
      ST_DONE:     if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end
  assign out_pixel_value  = res_val_r;
  assign out_patched      = res_chg_r;
  assign out_out_of_range = res_oor_r;

  // datapath
  // fits_r: 1 while in the range-check sweep over the neighbours (1..4);
  // swept_r once it has passed, then the read pass starts at the centre.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_valid) begin
        func_r <= in_func; x_r <= in_pos_x; y_r <= in_pos_y; wv_r <= in_write_value;
        pix_r <= 3'd0; fits_r <= 1'b0; swept_r <= 1'b0; sum_r <= '0; cnt_r <= '0;
        res_val_r <= '0; res_chg_r <= 1'b0; res_oor_r <= 1'b0;
      end
      ST_ADDR: begin
        base_r  <= EW'(cur_y) * EW'(rbytes_r);
        start_r <= 17'(cur_x) * 17'(d);
        bidx_r  <= 2'd0; acc_r <= '0;
      end
      ST_CHECK: begin
        inside_r <= (pix_r == 3'd0 && !fits_r) ? inside_c : inside_r;
        if (!fits_c) begin
          res_oor_r <= 1'b1;
        end else if (func_r == FUNC_WRITE) begin
          nv_r <= wv_r & dmask;
        end else if (pix_r == 3'd0 && func_r == FUNC_PATCH && !fits_r && !swept_r &&
                     inside_c) begin
          fits_r <= 1'b1;
        end
      end
      ST_RD_TAKE: begin
        acc_r  <= {acc_r[15:0], rdata};
        bidx_r <= bidx_r + 2'd1;
      end
      ST_NEXT: begin
        if (fits_r) begin
          if (pix_r == 3'd4) begin pix_r <= 3'd0; fits_r <= 1'b0; swept_r <= 1'b1; end
          else pix_r <= pix_r + 3'd1;
        end else if (pix_r == 3'd0) begin
          old_r <= pix_val; res_val_r <= pix_val;
          nv_r <= (func_r == FUNC_PATCH && inside_r && !interp_c && rmode_r == RM_ZERO) ?
                  14'd0 : pix_val;
          pix_r <= need_nb ? 3'd1 : 3'd0;
        end else begin
          if (pix_val != 14'd0) begin
            sum_r <= sum_r + 16'(pix_val); cnt_r <= cnt_r + 3'd1;
          end
          pix_r <= (pix_r == 3'd4) ? 3'd0 : pix_r + 3'd1;
        end
      end
      ST_DIV: begin
        // result of the patch; point the address back at the centre pixel
        nv_r      <= nv_c;
        res_val_r <= nv_c;
        res_chg_r <= (nv_c != old_r);
        base_r    <= EW'(cur_y) * EW'(rbytes_r);
        start_r   <= 17'(cur_x) * 17'(d);
        bidx_r    <= 2'd0;
      end
      ST_WR_BYTE: begin
        bidx_r <= bidx_r + 2'd1;
        if (func_r == FUNC_WRITE) res_val_r <= nv_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import prbp_pkg::*;

  localparam int STORE = 1048576;

  typedef struct packed {
    logic [13:0] pix;
    logic        chg;
    logic        oor;
  } px_result_t;

  // Frame model plus expected-result queue. Tracks which store bits have
  // been written so that reads of undefined bytes are never issued.
  class pixel_store_sb;
    bit [7:0] mem [longint unsigned];
    bit [7:0] known [longint unsigned];
    logic [1:0] depth_code = DEPTH_12;
    int unsigned rbytes, rpix, rows;
    logic [1:0] rmode = RM_OFF;
    bit force_on;
    px_result_t want_q[$];
    int errors;
    int n_patched, n_oor;

    function int bits_of();
      case (depth_code)
        DEPTH_10: return 10;
        DEPTH_12: return 12;
        default:  return 14;
      endcase
    endfunction

    function longint unsigned addr_of(longint unsigned base, longint unsigned b);
      return base + 2 * (b >> 4) + (((b & 15) < 8) ? 1 : 0);
    endfunction

    function bit fits(int x, int y);
      longint unsigned base, st;
      base = longint'(y) * rbytes;
      st = longint'(x) * bits_of();
      for (int k = 0; k < bits_of(); k++)
        if (addr_of(base, st + k) >= STORE) return 0;
      return 1;
    endfunction

    function bit known_px(int x, int y);
      longint unsigned base, st, b, a;
      bit [7:0] m;
      base = longint'(y) * rbytes;
      st = longint'(x) * bits_of();
      for (int k = 0; k < bits_of(); k++) begin
        b = st + k;
        a = addr_of(base, b);
        m = 8'h80 >> (b & 7);
        if (!known.exists(a) || (known[a] & m) == 0) return 0;
      end
      return 1;
    endfunction

    function int rd(int x, int y);
      longint unsigned base, st, b, a;
      int v;
      base = longint'(y) * rbytes;
      st = longint'(x) * bits_of();
      v = 0;
      for (int k = 0; k < bits_of(); k++) begin
        b = st + k;
        a = addr_of(base, b);
        v = (v << 1) | (mem.exists(a) ? ((mem[a] >> (7 - (b & 7))) & 1) : 0);
      end
      return v;
    endfunction

    function void wr(int x, int y, int v);
      longint unsigned base, st, b, a;
      bit [7:0] m;
      base = longint'(y) * rbytes;
      st = longint'(x) * bits_of();
      for (int k = 0; k < bits_of(); k++) begin
        b = st + k;
        a = addr_of(base, b);
        m = 8'h80 >> (b & 7);
        if (!mem.exists(a)) begin
          mem[a] = 0;
          known[a] = 0;
        end
        if ((v >> (bits_of() - 1 - k)) & 1) mem[a] |= m;
        else mem[a] &= ~m;
        known[a] |= m;
      end
    endfunction

    function bit inner(int x, int y);
      return x >= 2 && x + 2 < rpix && y >= 2 && y + 2 < rows;
    endfunction

    // true when the op touches only written bits (or is flagged before any read)
    function bit safe(logic [1:0] f, int x, int y);
      if (f == FUNC_READ) return !fits(x, y) || known_px(x, y);
      if (f != FUNC_PATCH) return 1;
      if (!fits(x, y)) return 1;
      if (!inner(x, y)) return known_px(x, y);
      if (!fits(x-2, y-2) || !fits(x+2, y-2) || !fits(x-2, y+2) || !fits(x+2, y+2))
        return 1;
      return known_px(x, y) && known_px(x-2, y-2) && known_px(x+2, y-2) &&
             known_px(x-2, y+2) && known_px(x+2, y+2);
    endfunction

    function void cfg_set(reg_idx_t idx, int unsigned d);
      case (idx)
        REG_DEPTH:  depth_code = d[1:0];
        REG_RBYTES: rbytes = d & 16'hFFFF;
        REG_RPIX:   rpix = d & 13'h1FFF;
        REG_ROWS:   rows = d & 13'h1FFF;
        REG_RMODE:  rmode = d[1:0];
        REG_FORCE:  force_on = d[0];
        default: ;
      endcase
    endfunction

    function void note_txn(logic [1:0] f, int x, int y, int wv);
      px_result_t r;
      int old, nv, sum, cnt, p, nx, ny;
      bit ok, ins;
      r = '0;
      case (f)
        FUNC_READ: begin
          if (fits(x, y)) r.pix = 14'(rd(x, y));
          else r.oor = 1;
        end
        FUNC_WRITE: begin
          if (fits(x, y)) begin
            nv = wv & ((1 << bits_of()) - 1);
            wr(x, y, nv);
            r.pix = 14'(nv);
          end else r.oor = 1;
        end
        FUNC_PATCH: begin
          ins = inner(x, y);
          ok = fits(x, y);
          if (ok && ins)
            ok = fits(x-2, y-2) && fits(x+2, y-2) && fits(x-2, y+2) && fits(x+2, y+2);
          if (!ok) r.oor = 1;
          else begin
            old = rd(x, y);
            nv = old;
            if (ins) begin
              if (force_on || rmode == RM_INTERP) begin
                sum = 0;
                cnt = 0;
                for (int n = 0; n < 4; n++) begin
                  nx = n[0] ? x + 2 : x - 2;
                  ny = n[1] ? y + 2 : y - 2;
                  p = rd(nx, ny);
                  if (p != 0) begin
                    sum += p;
                    cnt++;
                  end
                end
                if (cnt != 0) nv = sum / cnt;
              end else if (rmode == RM_ZERO) nv = 0;
            end
            if (nv != old) begin
              wr(x, y, nv);
              r.chg = 1;
            end
            r.pix = 14'(nv);
          end
        end
        default: ;
      endcase
      if (r.chg) n_patched++;
      if (r.oor) n_oor++;
      want_q.push_back(r);
    endfunction

    function void check_txn(logic [13:0] pix, logic chg, logic oor);
      px_result_t w;
      if (want_q.size() == 0) begin
        $error("result with nothing expected: pixel_value %0d", pix);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (pix !== w.pix) begin
        $error("pixel_value expected %0d actual %0d", w.pix, pix);
        errors++;
      end
      if (chg !== w.chg) begin
        $error("patched expected %0d actual %0d", w.chg, chg);
        errors++;
      end
      if (oor !== w.oor) begin
        $error("out_of_range expected %0d actual %0d", w.oor, oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_func = 0;
  logic [12:0] in_pos_x = 0;
  logic [12:0] in_pos_y = 0;
  logic [13:0] in_write_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [13:0] out_pixel_value;
  logic        out_patched;
  logic        out_out_of_range;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  packed_raw_bad_pixel_patcher_core DUT (.*);

  always #6 clk = ~clk;

  pixel_store_sb sb = new();

  // idling: 0 none, 1 sender idle, 2 receiver stall, 3 both
  int  idle_mode = 0;
  bit  in_took = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  n_items = 0;

  function int send_gap_pct();
    return (idle_mode == 1) ? 87 : (idle_mode == 3) ? 37 : 0;
  endfunction

  // Monitor: values sampled at the rising edge are pre-update.
  always @(posedge clk) begin
    in_took = in_valid && in_ready && rst_n;
    if (in_took) begin
      sb.note_txn(in_func, in_pos_x, in_pos_y, in_write_value);
      n_items++;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_txn(out_pixel_value, out_patched, out_out_of_range);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready = 0;
      hold_left--;
    end else begin
      out_ready = $urandom_range(1, 100) >
                  ((idle_mode == 2) ? 87 : (idle_mode == 3) ? 37 : 0);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next transaction unless a gap is drawn.
  task automatic send_txn(logic [1:0] f, int x, int y, int wv);
    if (!sb.safe(f, x, y)) f = FUNC_WRITE; // never read undefined store bytes
    while ($urandom_range(1, 100) <= send_gap_pct()) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_func = f;
    in_pos_x = 13'(x);
    in_pos_y = 13'(y);
    in_write_value = 14'(wv);
    do @(negedge clk); while (!in_took);
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.want_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, int unsigned d);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = 16'(d);
    sb.cfg_set(idx, d);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function int rand_px();
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16383);
  endfunction

  // Programme every register, then write every pixel of a small frame.
  task automatic start_phase(int dcode, int rp, int rc, int rb, int rm, int frc,
                             int fx, int fy);
    drain();
    cfg_write(REG_DEPTH, dcode);
    cfg_write(REG_RBYTES, rb);
    cfg_write(REG_RPIX, rp);
    cfg_write(REG_ROWS, rc);
    cfg_write(REG_RMODE, rm);
    cfg_write(REG_FORCE, frc);
    for (int y = 0; y < fy; y++)
      for (int x = 0; x < fx; x++)
        send_txn(FUNC_WRITE, x, y, rand_px());
  endtask

  // Mostly patches and reads inside the frame, some wild accesses.
  task automatic random_ops(int count, int fx, int fy);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 15 == 0) idle_mode = (i / 15) % 4;
      if (i == count / 4 && idle_mode != 2) hold_req = 1;
      r = $urandom_range(0, 99);
      if (r < 45)      send_txn(FUNC_PATCH, $urandom_range(0, fx-1), $urandom_range(0, fy-1),
                                $urandom_range(0, 16383));
      else if (r < 68) send_txn(FUNC_READ, $urandom_range(0, fx-1), $urandom_range(0, fy-1),
                                $urandom_range(0, 16383));
      else if (r < 88) send_txn(FUNC_WRITE, $urandom_range(0, fx-1), $urandom_range(0, fy-1),
                                rand_px());
      else if (r < 94) send_txn(FUNC_WRITE, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                $urandom_range(0, 16383));
      else if (r < 97) send_txn(2'($urandom_range(0, 2)), $urandom_range(0, 8191),
                                $urandom_range(0, 8191), $urandom_range(0, 16383));
      else             send_txn(FUNC_NONE, $urandom_range(0, 8191), $urandom_range(0, 8191),
                                $urandom_range(0, 16383));
    end
  endtask

  function int pack_bytes(int rp, int d);
    return ((rp * d + 15) / 16) * 2;
  endfunction

  initial begin
    int rp, rc;
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // 10-bit, interpolate, with the directed items
    rp = 10; rc = 8;
    start_phase(DEPTH_10, rp, rc, pack_bytes(rp, 10), RM_INTERP, 0, rp, rc);
    send_txn(FUNC_NONE, 8191, 8191, 16383);
    send_txn(FUNC_WRITE, 8191, 8191, 16383);
    send_txn(FUNC_READ, 8191, 8191, 0);
    send_txn(FUNC_READ, 0, 0, 0);
    send_txn(FUNC_PATCH, 0, 0, 0);            // border
    send_txn(FUNC_PATCH, 1, 3, 0);            // border
    send_txn(FUNC_PATCH, rp - 2, 3, 0);       // border, right
    send_txn(FUNC_PATCH, 3, rc - 2, 0);       // border, bottom
    send_txn(FUNC_PATCH, 2, 2, 0);
    send_txn(FUNC_PATCH, rp - 3, rc - 3, 0);
    for (int i = 0; i < 4; i++) send_txn(FUNC_WRITE, (i % 2) ? 3 : 7, (i / 2) ? 5 : 1, 0);
    send_txn(FUNC_PATCH, 5, 3, 0);            // all neighbours zero
    send_txn(FUNC_WRITE, 4, 4, 16383);        // masked to depth
    send_txn(FUNC_READ, 4, 4, 0);
    random_ops(60, rp, rc);

    // 12-bit, zero mode, padded rows
    rp = 12; rc = 9;
    start_phase(DEPTH_12, rp, rc, pack_bytes(rp, 12) + 6, RM_ZERO, 0, rp, rc);
    random_ops(60, rp, rc);

    // 14-bit, mode off but forced interpolation
    rp = 9; rc = 7;
    start_phase(DEPTH_14, rp, rc, pack_bytes(rp, 14), RM_OFF, 1, rp, rc);
    random_ops(60, rp, rc);

    // depth code three and removal code three
    rp = 11; rc = 6;
    start_phase(3, rp, rc, pack_bytes(rp, 14), 3, 0, rp, rc);
    random_ops(60, rp, rc);

    // zero row pitch: every row aliases row 0
    rp = 8; rc = 8;
    start_phase($urandom_range(0, 2), rp, rc, 0, RM_INTERP, 0, rp, 1);
    random_ops(55, rp, rc);

    // largest sizes and pitch; far rows fall past the store
    start_phase(DEPTH_14, 8191, 8191, 65535, RM_INTERP, 1, 11, 9);
    send_txn(FUNC_READ, 8191, 8191, 0);
    send_txn(FUNC_WRITE, 8191, 8191, 16383);
    send_txn(FUNC_PATCH, 8191, 8191, 0);
    send_txn(FUNC_PATCH, 4, 15, 0);           // neighbour row past the store
    random_ops(60, 11, 9);
    send_txn(FUNC_READ, $urandom_range(0, 8191), $urandom_range(20, 8191), 0);

    drain();
    idle_mode = 0;
    repeat (100) @(negedge clk);
    if (sb.want_q.size() != 0) begin
      $error("%0d results never arrived", sb.want_q.size());
      sb.errors++;
    end
    $display("Ran %0d transactions over six register settings (all depths, modes, pitches).",
             n_items);
    $display("Patches that changed a pixel: %0d, out-of-range accesses: %0d.",
             sb.n_patched, sb.n_oor);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
src/prbp_pkg.sv
src/prbp_ram.sv
src/packed_raw_bad_pixel_patcher_core.sv
dv/testbench.sv
